// ===== design/rnrb_pkg.sv =====
package rnrb_pkg;

  localparam int SLOTS = 2048;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_NACK   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [1:0] REG_NACK_ENABLE = 2'd0;
  localparam logic [1:0] REG_RTX_ENABLE  = 2'd1;
  localparam logic [1:0] REG_DEFAULT_RTT = 2'd2;

  localparam logic KIND_RESEND = 1'b0;
  localparam logic KIND_RTT    = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] seq;
    logic [15:0] packet_handle;
    logic [47:0] now_ms;
    logic [31:0] last_sr_stamp;
    logic [31:0] sr_delay;
    logic [31:0] now_compact_ntp;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] seq_out;
    logic [15:0] handle_out;
    logic        via_rtx;
    logic [15:0] rtx_seq_out;
    logic [7:0]  resend_tries;
    logic        retry_excess;
    logic [29:0] rtt_q4;
    logic [29:0] avg_rtt_q4;
  } out_item_t;

  typedef struct packed {
    logic        nack_enable;
    logic        rtx_enable;
    logic [29:0] default_rtt_q4;
  } cfg_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic        is_record;
    logic        is_nack;
    logic        lsr_zero;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [47:0] now_ms;
    logic [32:0] delta;
  } op_t;

endpackage

// ===== design/rnrb_front.sv =====
module rnrb_front import rnrb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     op_valid,
  input  logic     op_stall,
  output op_t      op
);

  op_t        q [QDEPTH];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       accept, pop, keep;
  op_t        cls;
  logic [32:0] sum;

  assign in_stall = (cnt == 2'(QDEPTH));
  assign accept = in_valid && !in_stall;
  assign op_valid = (cnt != 2'd0);
  assign pop = op_valid && !op_stall;
  assign op = q[rp];

  always_comb begin
    sum = {1'b0, in_data.last_sr_stamp} + {1'b0, in_data.sr_delay};
    cls = '0;
    cls.is_record = (in_data.command == CMD_RECORD);
    cls.is_nack = (in_data.command == CMD_NACK);
    cls.lsr_zero = (in_data.last_sr_stamp == 32'd0);
    cls.seq = in_data.seq;
    cls.handle = in_data.packet_handle;
    cls.now_ms = in_data.now_ms;
    if (in_data.sr_delay != 32'd0 && {1'b0, in_data.now_compact_ntp} > sum) begin
      cls.delta = {1'b0, in_data.now_compact_ntp} - sum;
    end
    unique case (in_data.command)
      CMD_RECORD: keep = cfg.nack_enable;
      CMD_NACK:   keep = cfg.nack_enable;
      CMD_REPORT: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept && keep) begin
        q[wp] <= cls;
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(accept && keep) - 2'(pop);
    end
  end

endmodule

// ===== design/rnrb_back.sv =====
module rnrb_back import rnrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_stall,
  input  op_t       op,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_RTT  = 2'd2;

  logic        mem_valid  [SLOTS];
  logic [15:0] mem_seq    [SLOTS];
  logic [15:0] mem_handle [SLOTS];
  logic [7:0]  mem_retry  [SLOTS];
  logic [47:0] mem_last   [SLOTS];

  logic [1:0]  state;
  logic        clearing;
  logic [IDX_W-1:0] clr_idx;
  op_t         cur;
  logic [IDX_W-1:0] idx;
  logic [15:0] rd_seq, rd_handle;
  logic [7:0]  rd_retry;
  logic [47:0] rd_last;
  logic        rd_valid;
  logic [29:0] avg_rtt;
  logic [15:0] rtx_ctr;
  logic [39:0] prod;

  logic        hit, pace_ok, fire;
  logic [49:0] e;
  logic [54:0] scaled;
  logic [7:0]  r_next;
  logic [31:0] avg_sum;
  logic [29:0] rtt;
  out_item_t   res_resend, res_rtt;

  assign idx = op.seq[IDX_W-1:0];
  assign op_stall = clearing || (state != ST_IDLE) || (out_valid && out_stall);

  always_comb begin
    hit = rd_valid && rd_seq == cur.seq;
    e = {2'b0, cur.now_ms} - {2'b0, rd_last} + 50'd10;
    scaled = (avg_rtt > 30'd160) ? {e, 5'b0} : {e[49], e, 4'b0};
    pace_ok = !scaled[54] && (scaled >= 55'(avg_rtt));
    fire = hit && (rd_retry == 8'd0 || pace_ok);
    r_next = (rd_retry == 8'd0) ? 8'd1 : (rd_retry == 8'd255 ? 8'd255 : rd_retry + 8'd1);
    rtt = cur.lsr_zero ? cfg.default_rtt_q4 : prod[38:9];
    avg_sum = {2'b0, avg_rtt} + {1'b0, avg_rtt, 1'b0} + {2'b0, prod[38:9]};
    res_resend = '0;
    res_resend.result_kind = KIND_RESEND;
    res_resend.seq_out = cur.seq;
    res_resend.handle_out = rd_handle;
    res_resend.via_rtx = cfg.rtx_enable;
    res_resend.rtx_seq_out = cfg.rtx_enable ? rtx_ctr : 16'd0;
    res_resend.resend_tries = r_next;
    res_resend.retry_excess = r_next > 8'd5;
    res_rtt = '0;
    res_rtt.result_kind = KIND_RTT;
    res_rtt.rtt_q4 = rtt;
    res_rtt.avg_rtt_q4 = cur.lsr_zero ? avg_rtt : avg_sum[31:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      out_valid <= 1'b0;
      avg_rtt <= '0;
      rtx_ctr <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (clearing) begin
        mem_valid[clr_idx] <= 1'b0;
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(SLOTS - 1)) clearing <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (op_valid && !op_stall) begin
          cur <= op;
          rd_valid <= mem_valid[idx];
          rd_seq <= mem_seq[idx];
          rd_handle <= mem_handle[idx];
          rd_retry <= mem_retry[idx];
          rd_last <= mem_last[idx];
          prod <= 40'(op.delta) * 40'd125;
          if (op.is_record) begin
            mem_valid[idx] <= 1'b1;
            mem_seq[idx] <= op.seq;
            mem_handle[idx] <= op.handle;
            mem_retry[idx] <= 8'd0;
            mem_last[idx] <= '0;
          end else if (op.is_nack) state <= ST_LOOK;
          else state <= ST_RTT;
        end
        ST_LOOK: begin
          state <= ST_IDLE;
          if (fire) begin
            mem_retry[cur.seq[IDX_W-1:0]] <= r_next;
            mem_last[cur.seq[IDX_W-1:0]] <= cur.now_ms;
            out_valid <= 1'b1;
            out_data <= res_resend;
            if (cfg.rtx_enable) rtx_ctr <= rtx_ctr + 16'd1;
          end
        end
        ST_RTT: begin
          state <= ST_IDLE;
          out_valid <= 1'b1;
          out_data <= res_rtt;
          if (!cur.lsr_zero) avg_rtt <= avg_sum[31:2];
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/rtp_nack_retransmit_buffer.sv =====
// RTP NACK retransmission buffer.
// Input channel in_valid/in_stall/in_data carries record, NACK and report
// transactions; output channel out_valid/out_stall/out_data carries resend
// orders and RTT reports. Configuration is written through cfg_write,
// cfg_index and cfg_data; the user writes it only while the block is
// idle, which the block itself does not enforce. A front stage classifies
// each transaction and queues it (two entries), dropping records and NACKs
// while NACK is disabled. The back stage reads the slot table into its
// registers in the idle state, where a record is also written; a NACK
// may then update its slot and form a resend order in LOOK, a report an
// RTT report in RTT. The back takes a new transaction while its result is
// taken, but none while in LOOK or RTT. A result passes the front queue,
// the back read registers and the result register. Reset clears the
// smoothed RTT and the RTX counter and restores default register values,
// then the back clears the slot valid table in a pass over all 2048 slots;
// meanwhile the queue fills and in_stall rises. While the receiver stalls
// the result holds, the back waits and the queue fills until in_stall rises.
module rtp_nack_retransmit_buffer import rnrb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);

  cfg_t cfg;
  op_t  op;
  logic op_valid, op_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nack_enable <= 1'b0;
      cfg.rtx_enable <= 1'b0;
      cfg.default_rtt_q4 <= 30'd1600;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NACK_ENABLE: cfg.nack_enable <= cfg_data[0];
        REG_RTX_ENABLE:  cfg.rtx_enable <= cfg_data[0];
        REG_DEFAULT_RTT: cfg.default_rtt_q4 <= cfg_data;
        default: ;
      endcase
    end
  end

  rnrb_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .cfg,
    .op_valid, .op_stall, .op
  );

  rnrb_back u_back (
    .clk, .rst, .op_valid, .op_stall, .op, .cfg,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== design/rnrb_checker.sv =====
module rnrb_props import rnrb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_rtt_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_RTT |->
      out_data.seq_out == 16'd0 && out_data.resend_tries == 8'd0)
    else $error("report carries resend fields");

  a_excess: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_RESEND |->
      out_data.retry_excess == (out_data.resend_tries > 8'd5) &&
      out_data.resend_tries != 8'd0)
    else $error("retry flag mismatch");

endmodule

bind rtp_nack_retransmit_buffer rnrb_props u_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
